// File: rtl/core/crtp_pkg.sv
// Shared types and constants for the checker ramp test pattern generator.
package crtp_pkg;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    // Quotient bits of both ramp divisions; an interior ramp stays below 200.
    localparam int Q_W     = 8;
    // Holds 200 * 4095 and the divisor shifted up by Q_W - 1.
    localparam int REM_W   = 21;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0]   DIM_RESET    = 13'd1024;
    localparam logic [COORD_W:0]   BORDER       = 13'd8;
    localparam logic [REM_W-1:0]   RAMP_X_SCALE = 21'd200;
    localparam logic [REM_W-1:0]   RAMP_Y_SCALE = 21'd160;

    localparam logic [CHAN_W-1:0] RED_BASE    = 8'd40;
    localparam logic [CHAN_W-1:0] BLUE_BASE   = 8'd200;
    localparam logic [CHAN_W-1:0] LIGHT_GREEN = 8'd70;
    localparam logic [CHAN_W-1:0] EDGE_RED    = 8'd255;
    localparam logic [CHAN_W-1:0] EDGE_GREEN  = 8'd80;
    localparam logic [CHAN_W-1:0] EDGE_BLUE   = 8'd0;
    localparam logic [CHAN_W-1:0] DARK_RED    = 8'd16;
    localparam logic [CHAN_W-1:0] DARK_GREEN  = 8'd18;
    localparam logic [CHAN_W-1:0] DARK_BLUE   = 8'd24;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [1:0] {
        CLS_BORDER,
        CLS_LIGHT,
        CLS_DARK
    } pix_class_t;

    typedef struct packed {
        pix_class_t        cls;
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
    } cell_word_t;

endpackage

// File: rtl/core/crtp_if.sv
// Valid/ready channel interfaces for pixel coordinates and RGBA results.
interface crtp_pix_if;
    logic                         valid;
    logic                         ready;
    logic [crtp_pkg::COORD_W-1:0] pixel_x;
    logic [crtp_pkg::COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface crtp_rgba_if;
    logic                        valid;
    logic                        ready;
    logic [crtp_pkg::CHAN_W-1:0] red;
    logic [crtp_pkg::CHAN_W-1:0] green;
    logic [crtp_pkg::CHAN_W-1:0] blue;
    logic [crtp_pkg::CHAN_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

// File: rtl/core/checker_ramp_test_pattern.sv
// Top level of the checker ramp test pattern generator.
// An accepted coordinate reaches its RGBA word through one entry stage, eight
// division cells (one quotient bit each) and one output register.
// Throughput is one word per cycle unless the output stalls; every stage holds
// its own valid bit, so bubbles close up while the output is stalled.
// Reset clears all valid bits and sets both frame dimensions to 1024, or to MAX_DIM if that is smaller.
module checker_ramp_test_pattern #(
    parameter int MAX_DIM = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [crtp_pkg::DIM_W-1:0] cfg_data,
    crtp_pix_if.sink                   pix,
    crtp_rgba_if.source                rgba
);
    import crtp_pkg::*;

    localparam logic [DIM_W-1:0] DIM_INIT =
        (int'(DIM_RESET) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_RESET;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [DIM_W-1:0] cfg_clamped;

    logic       stg_valid [0:Q_W];
    logic       stg_ready [0:Q_W];
    cell_word_t stg_word  [0:Q_W];

    logic              out_valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    // Written dimensions saturate at the largest supported frame.
    assign cfg_clamped = (int'(cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_INIT;
            frame_height_reg <= DIM_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_clamped;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_clamped;
                default:          ;
            endcase
        end
    end

    crtp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_valid    (stg_valid[0]),
        .out_ready    (stg_ready[0]),
        .out_word     (stg_word[0])
    );

    for (genvar k = 0; k < Q_W; k++)
    begin : g_cell
        crtp_div_cell #(
            .STEP (Q_W - 1 - k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .frame_width  (frame_width_reg),
            .frame_height (frame_height_reg),
            .in_valid     (stg_valid[k]),
            .in_ready     (stg_ready[k]),
            .in_word      (stg_word[k]),
            .out_valid    (stg_valid[k+1]),
            .out_ready    (stg_ready[k+1]),
            .out_word     (stg_word[k+1])
        );
    end

    assign stg_ready[Q_W] = !out_valid_reg || rgba.ready;

    always_comb
    begin
        case (stg_word[Q_W].cls)
            CLS_LIGHT:
            begin
                red_next   = RED_BASE + stg_word[Q_W].q_x;
                green_next = LIGHT_GREEN;
                blue_next  = BLUE_BASE - stg_word[Q_W].q_y;
            end
            CLS_DARK:
            begin
                red_next   = DARK_RED;
                green_next = DARK_GREEN;
                blue_next  = DARK_BLUE;
            end
            default:
            begin
                red_next   = EDGE_RED;
                green_next = EDGE_GREEN;
                blue_next  = EDGE_BLUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_ready[Q_W])
        begin
            out_valid_reg <= stg_valid[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_valid[Q_W] && stg_ready[Q_W])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgba.valid = out_valid_reg;
    assign rgba.red   = red_reg;
    assign rgba.green = green_reg;
    assign rgba.blue  = blue_reg;
    assign rgba.alpha = ALPHA_OPAQUE;

endmodule

// File: rtl/core/crtp_front.sv
// Entry stage: classifies the pixel and forms the two ramp dividends.
module crtp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    crtp_pix_if.sink                  pix,
    input  logic [crtp_pkg::DIM_W-1:0] frame_width,
    input  logic [crtp_pkg::DIM_W-1:0] frame_height,
    output logic                      out_valid,
    input  logic                      out_ready,
    output crtp_pkg::cell_word_t      out_word
);
    import crtp_pkg::*;

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;
    logic       is_border;
    logic [COORD_W:0] x_ext;
    logic [COORD_W:0] y_ext;

    assign pix.ready = !valid_reg || out_ready;

    always_comb
    begin
        x_ext = {1'b0, pix.pixel_x};
        y_ext = {1'b0, pix.pixel_y};
        is_border = (x_ext < BORDER) || (y_ext < BORDER) ||
                    (x_ext + BORDER >= frame_width) || (y_ext + BORDER >= frame_height);
        word_next.rem_x = REM_W'(pix.pixel_x) * RAMP_X_SCALE;
        word_next.rem_y = REM_W'(pix.pixel_y) * RAMP_Y_SCALE;
        word_next.q_x   = '0;
        word_next.q_y   = '0;
        // Cells alternate on bit 6 of each coordinate; the top-left cell is light.
        if (is_border)
        begin
            word_next.cls = CLS_BORDER;
        end
        else if ((pix.pixel_x[6] ^ pix.pixel_y[6]) == 1'b0)
        begin
            word_next.cls = CLS_LIGHT;
        end
        else
        begin
            word_next.cls = CLS_DARK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix.ready)
        begin
            valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: rtl/core/crtp_div_cell.sv
// One restoring-division cell: settles one quotient bit of both ramps.
module crtp_div_cell #(
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [crtp_pkg::DIM_W-1:0] frame_width,
    input  logic [crtp_pkg::DIM_W-1:0] frame_height,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  crtp_pkg::cell_word_t       in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output crtp_pkg::cell_word_t       out_word
);
    import crtp_pkg::*;

    logic             valid_reg;
    cell_word_t       word_reg;
    cell_word_t       word_next;
    logic [REM_W:0]   diff_x;
    logic [REM_W:0]   diff_y;
    logic [Q_W-1:0]   bit_mask;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        bit_mask  = Q_W'(1) << STEP;
        diff_x    = {1'b0, in_word.rem_x} - ((REM_W + 1)'(frame_width) << STEP);
        diff_y    = {1'b0, in_word.rem_y} - ((REM_W + 1)'(frame_height) << STEP);
        word_next = in_word;
        // A clear borrow bit means the shifted divisor fits.
        if (!diff_x[REM_W])
        begin
            word_next.rem_x = diff_x[REM_W-1:0];
            word_next.q_x   = in_word.q_x | bit_mask;
        end
        if (!diff_y[REM_W])
        begin
            word_next.rem_y = diff_y[REM_W-1:0];
            word_next.q_y   = in_word.q_y | bit_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
